### hdl/bba_pkg.sv
`timescale 1ns / 1ps

package bba_pkg;

    // Request codes
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_SPACE  = 2'd1,
        ST_BAD_LEVEL = 2'd2,
        ST_NOT_ALLOC = 2'd3
    } status_t;

    typedef struct packed {
        logic       req_type;
        logic [2:0] want_level;
        logic [4:0] block_address;
    } req_t;

    typedef struct packed {
        status_t    status;
        logic [4:0] granted_address;
        logic [2:0] freed_level;
    } rsp_t;

    // One tree node as stored
    typedef struct packed {
        logic free;
        logic split;
    } node_t;

    localparam node_t NODE_CLEAN = '{free: 1'b1, split: 1'b0};
    localparam node_t NODE_USED  = '{free: 1'b0, split: 1'b0};
    localparam node_t NODE_SPLIT = '{free: 1'b1, split: 1'b1};

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_DOWN_LEFT,
        IDX_DOWN_ADDR,
        IDX_UP,
        IDX_NEXT
    } idx_op_t;

    typedef enum logic {
        RD_NODE,
        RD_BUDDY
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_NODE,
        WR_PARENT,
        WR_CLEAR
    } wr_sel_t;

    typedef struct packed {
        logic    load;
        idx_op_t idx_op;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    wr_en;
        wr_sel_t wr_sel;
        node_t   wr_data;
        logic    clr_step;
        logic    grab_grant;
        logic    grab_level;
        logic    out_load;
        status_t out_status;
    } cmd_t;

    typedef struct packed {
        logic req_free;
        logic lvl_bad;
        logic addr_bad;
        logic rd_free;
        logic rd_split;
        logic at_target;
        logic at_leaf;
        logic is_root;
        logic is_odd;
        logic idx_zero;
        logic path_zero;
        logic clr_last;
    } sts_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_A_READ,
        S_A_CHECK,
        S_A_ADV,
        S_A_COMMIT,
        S_A_SPLIT,
        S_F_SCAN,
        S_F_CHECK,
        S_M_READ,
        S_M_CHECK,
        S_RESULT
    } state_t;

endpackage

### hdl/buddy_block_allocator.sv
`timescale 1ns / 1ps

// Binary buddy allocator over a tree of 2^(TREE_LEVELS+1)-1 nodes kept in a
// one-port node memory (free and split bit per node, heap order). After reset
// the block sweeps the memory once, one node per cycle, writing all
// 2^(TREE_LEVELS+1) entries (64 at the default) clean before in_ready first
// rises. One request is worked at a time; the result register lets the next
// request be taken while a result beat waits. Every node lookup is a read,
// whose data is registered, then a check of that data. An allocate runs a
// left-first search: it descends through free nodes above the wanted level,
// and advances past a used or split node by climbing out of right children
// and stepping to the next sibling. On success it marks the node used and
// every ancestor split. A free skips the levels where the address is not
// block-aligned, looks up the aligned levels until it finds the used node,
// then merges upward until it reaches the root or a buddy in use stops it.
// A request with a level that is too deep goes straight to the result.
module buddy_block_allocator #(
    parameter int TREE_LEVELS = 5
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  bba_pkg::req_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output bba_pkg::rsp_t out_data
);

    bba_pkg::cmd_t cmd;
    bba_pkg::sts_t sts;

    bba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    bba_dp #(
        .TREE_LEVELS (TREE_LEVELS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cmd      (cmd),
        .sts      (sts),
        .out_data (out_data)
    );

endmodule

### hdl/bba_dp.sv
`timescale 1ns / 1ps

module bba_dp #(
    parameter int TREE_LEVELS = 5
) (
    input  logic          clk,
    input  logic          rst_n,
    input  bba_pkg::req_t in_data,
    input  bba_pkg::cmd_t cmd,
    output bba_pkg::sts_t sts,
    output bba_pkg::rsp_t out_data
);

    localparam int NW    = TREE_LEVELS + 1;
    localparam int AW    = TREE_LEVELS;
    localparam int LW    = $clog2(TREE_LEVELS + 1);
    localparam int DEPTH = 2 ** NW;

    logic [NW-1:0]  idx_reg, idx_next;
    logic [LW-1:0]  lvl_reg, lvl_next;
    logic [LW-1:0]  tgt_reg;
    logic [AW-1:0]  path_reg, path_next;
    logic           req_free_reg;
    logic           lvl_bad_reg;
    logic           addr_bad_reg;
    logic [4:0]     grant_reg;
    logic [2:0]     freed_reg;
    logic [NW-1:0]  clr_reg;
    bba_pkg::node_t rd_data_reg;
    bba_pkg::rsp_t  out_reg;

    bba_pkg::node_t mem [0:DEPTH-1];

    logic [NW-1:0]  rd_addr;
    logic [NW-1:0]  wr_addr;
    logic [LW-1:0]  sh_amt;
    logic [NW-1:0]  idx_sh;
    logic [4:0]     grant_val;

    always_comb
    begin
        idx_next  = idx_reg;
        lvl_next  = lvl_reg;
        path_next = path_reg;
        case (cmd.idx_op)
            bba_pkg::IDX_DOWN_LEFT:
            begin
                idx_next = idx_reg << 1;
                lvl_next = lvl_reg + LW'(1);
            end
            bba_pkg::IDX_DOWN_ADDR:
            begin
                idx_next  = {idx_reg[NW-2:0], path_reg[AW-1]};
                path_next = path_reg << 1;
                lvl_next  = lvl_reg + LW'(1);
            end
            bba_pkg::IDX_UP:
            begin
                idx_next = idx_reg >> 1;
                lvl_next = lvl_reg - LW'(1);
            end
            bba_pkg::IDX_NEXT:
            begin
                idx_next = idx_reg + NW'(1);
            end
            default:
            begin
            end
        endcase
        if (cmd.load)
        begin
            idx_next  = NW'(1);
            lvl_next  = '0;
            path_next = AW'(in_data.block_address);
        end
    end

    // Node start address: push the leading one up to bit TREE_LEVELS
    assign sh_amt    = LW'(TREE_LEVELS) - lvl_reg;
    assign idx_sh    = idx_reg << sh_amt;
    assign grant_val = 5'(idx_sh[AW-1:0]);

    assign rd_addr = (cmd.rd_sel == bba_pkg::RD_BUDDY) ? (idx_reg ^ NW'(1)) : idx_reg;

    always_comb
    begin
        case (cmd.wr_sel)
            bba_pkg::WR_NODE:   wr_addr = idx_reg;
            bba_pkg::WR_PARENT: wr_addr = idx_reg >> 1;
            bba_pkg::WR_CLEAR:  wr_addr = clr_reg;
            default:            wr_addr = idx_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (cmd.clr_step)
        begin
            clr_reg <= clr_reg + NW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        lvl_reg  <= lvl_next;
        path_reg <= path_next;
        if (cmd.load)
        begin
            req_free_reg <= (in_data.req_type == bba_pkg::REQ_FREE);
            lvl_bad_reg  <= (32'(in_data.want_level) > TREE_LEVELS);
            addr_bad_reg <= ((32'(in_data.block_address) >> TREE_LEVELS) != 32'd0);
            tgt_reg      <= LW'(in_data.want_level);
            grant_reg    <= '0;
            freed_reg    <= '0;
        end
        else
        begin
            if (cmd.grab_grant)
            begin
                grant_reg <= grant_val;
            end
            if (cmd.grab_level)
            begin
                freed_reg <= 3'(lvl_reg);
            end
        end
        if (cmd.out_load)
        begin
            out_reg.status          <= cmd.out_status;
            out_reg.granted_address <= grant_reg;
            out_reg.freed_level     <= freed_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= cmd.wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign sts.req_free  = req_free_reg;
    assign sts.lvl_bad   = lvl_bad_reg;
    assign sts.addr_bad  = addr_bad_reg;
    assign sts.rd_free   = rd_data_reg.free;
    assign sts.rd_split  = rd_data_reg.split;
    assign sts.at_target = (lvl_reg == tgt_reg);
    assign sts.at_leaf   = (lvl_reg == LW'(TREE_LEVELS));
    assign sts.is_root   = (idx_reg == NW'(1));
    assign sts.is_odd    = idx_reg[0];
    assign sts.idx_zero  = (idx_reg == '0);
    assign sts.path_zero = (path_reg == '0);
    assign sts.clr_last  = (clr_reg == {NW{1'b1}});

    assign out_data = out_reg;

endmodule

### hdl/bba_ctrl.sv
`timescale 1ns / 1ps

module bba_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    input  bba_pkg::sts_t sts,
    output bba_pkg::cmd_t cmd
);

    bba_pkg::state_t  state_reg, state_next;
    bba_pkg::status_t stat_reg, stat_next;
    logic             out_valid_reg, out_valid_next;
    logic             slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bba_pkg::S_CLEAR:
                if (sts.clr_last) state_next = bba_pkg::S_IDLE;
            bba_pkg::S_IDLE:
                if (in_valid) state_next = bba_pkg::S_DISPATCH;
            bba_pkg::S_DISPATCH:
            begin
                if (sts.req_free)
                    state_next = sts.addr_bad ? bba_pkg::S_RESULT : bba_pkg::S_F_SCAN;
                else
                    state_next = sts.lvl_bad ? bba_pkg::S_RESULT : bba_pkg::S_A_READ;
            end
            bba_pkg::S_A_READ:
                state_next = bba_pkg::S_A_CHECK;
            bba_pkg::S_A_CHECK:
            begin
                if (!sts.rd_free)
                    state_next = bba_pkg::S_A_ADV;
                else if (sts.at_target)
                    state_next = sts.rd_split ? bba_pkg::S_A_ADV : bba_pkg::S_A_COMMIT;
                else
                    state_next = bba_pkg::S_A_READ;
            end
            bba_pkg::S_A_ADV:
            begin
                if (sts.is_root)
                    state_next = bba_pkg::S_RESULT;
                else if (!sts.is_odd)
                    state_next = bba_pkg::S_A_READ;
            end
            bba_pkg::S_A_COMMIT:
                state_next = bba_pkg::S_A_SPLIT;
            bba_pkg::S_A_SPLIT:
                if (sts.idx_zero) state_next = bba_pkg::S_RESULT;
            bba_pkg::S_F_SCAN:
                if (sts.path_zero) state_next = bba_pkg::S_F_CHECK;
            bba_pkg::S_F_CHECK:
            begin
                if (!sts.rd_free)
                    state_next = bba_pkg::S_M_READ;
                else if (sts.at_leaf)
                    state_next = bba_pkg::S_RESULT;
                else
                    state_next = bba_pkg::S_F_SCAN;
            end
            bba_pkg::S_M_READ:
                state_next = sts.is_root ? bba_pkg::S_RESULT : bba_pkg::S_M_CHECK;
            bba_pkg::S_M_CHECK:
            begin
                if (sts.rd_free && !sts.rd_split)
                    state_next = bba_pkg::S_M_READ;
                else
                    state_next = bba_pkg::S_RESULT;
            end
            bba_pkg::S_RESULT:
                if (slot_free) state_next = bba_pkg::S_IDLE;
            default:
                state_next = bba_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        in_ready       = 1'b0;
        stat_next      = stat_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            bba_pkg::S_CLEAR:
            begin
                cmd.wr_en    = 1'b1;
                cmd.wr_sel   = bba_pkg::WR_CLEAR;
                cmd.wr_data  = bba_pkg::NODE_CLEAN;
                cmd.clr_step = 1'b1;
            end
            bba_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            bba_pkg::S_DISPATCH:
            begin
                if (sts.req_free)
                    stat_next = sts.addr_bad ? bba_pkg::ST_NOT_ALLOC : bba_pkg::ST_OK;
                else
                    stat_next = sts.lvl_bad ? bba_pkg::ST_BAD_LEVEL : bba_pkg::ST_OK;
            end
            bba_pkg::S_A_READ:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = bba_pkg::RD_NODE;
            end
            bba_pkg::S_A_CHECK:
            begin
                // Descend through free nodes above the wanted level
                if (sts.rd_free && !sts.at_target)
                    cmd.idx_op = bba_pkg::IDX_DOWN_LEFT;
            end
            bba_pkg::S_A_ADV:
            begin
                // Climb out of right children, then step to the next sibling
                if (sts.is_root)
                    stat_next = bba_pkg::ST_NO_SPACE;
                else if (sts.is_odd)
                    cmd.idx_op = bba_pkg::IDX_UP;
                else
                    cmd.idx_op = bba_pkg::IDX_NEXT;
            end
            bba_pkg::S_A_COMMIT:
            begin
                cmd.wr_en      = 1'b1;
                cmd.wr_sel     = bba_pkg::WR_NODE;
                cmd.wr_data    = bba_pkg::NODE_USED;
                cmd.grab_grant = 1'b1;
                cmd.idx_op     = bba_pkg::IDX_UP;
            end
            bba_pkg::S_A_SPLIT:
            begin
                if (!sts.idx_zero)
                begin
                    cmd.wr_en   = 1'b1;
                    cmd.wr_sel  = bba_pkg::WR_NODE;
                    cmd.wr_data = bba_pkg::NODE_SPLIT;
                    cmd.idx_op  = bba_pkg::IDX_UP;
                end
            end
            bba_pkg::S_F_SCAN:
            begin
                // Only look at levels where the address is block-aligned
                if (sts.path_zero)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = bba_pkg::RD_NODE;
                end
                else
                begin
                    cmd.idx_op = bba_pkg::IDX_DOWN_ADDR;
                end
            end
            bba_pkg::S_F_CHECK:
            begin
                if (!sts.rd_free)
                begin
                    cmd.wr_en      = 1'b1;
                    cmd.wr_sel     = bba_pkg::WR_NODE;
                    cmd.wr_data    = bba_pkg::NODE_CLEAN;
                    cmd.grab_level = 1'b1;
                end
                else if (sts.at_leaf)
                begin
                    stat_next = bba_pkg::ST_NOT_ALLOC;
                end
                else
                begin
                    cmd.idx_op = bba_pkg::IDX_DOWN_ADDR;
                end
            end
            bba_pkg::S_M_READ:
            begin
                if (!sts.is_root)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = bba_pkg::RD_BUDDY;
                end
            end
            bba_pkg::S_M_CHECK:
            begin
                if (sts.rd_free && !sts.rd_split)
                begin
                    cmd.wr_en   = 1'b1;
                    cmd.wr_sel  = bba_pkg::WR_PARENT;
                    cmd.wr_data = bba_pkg::NODE_CLEAN;
                    cmd.idx_op  = bba_pkg::IDX_UP;
                end
            end
            bba_pkg::S_RESULT:
            begin
                cmd.out_status = stat_reg;
                if (slot_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bba_pkg::S_CLEAR;
            stat_reg      <= bba_pkg::ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            stat_reg      <= stat_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

### test/buddy_block_allocator_tb.sv
`timescale 1ns / 1ps

module buddy_block_allocator_tb;

    localparam int LEVELS      = 5;
    localparam int NODES       = 2 << LEVELS;
    localparam int RANDOM_REQS = 950;
    localparam int LONG_HOLD   = 400;
    localparam int HOLD_AT     = 300;
    localparam int DRAIN_WAIT  = 300;
    localparam int STALL_LIMIT = 3000;

    // Tracks the block tree as the allocator should see it and holds the
    // responses still owed, oldest first.
    class buddy_tree_tracker;
        bit            node_free[NODES];
        bit            node_split[NODES];
        bba_pkg::rsp_t pending_rsp[$];
        logic [4:0]    live_addr[$];
        int            fails;
        int            alloc_reqs;
        int            free_reqs;
        int            status_seen[4];

        function new();
            foreach (node_free[k])
            begin
                node_free[k]  = 1'b1;
                node_split[k] = 1'b0;
            end
            fails      = 0;
            alloc_reqs = 0;
            free_reqs  = 0;
            foreach (status_seen[k])
                status_seen[k] = 0;
        endfunction

        function bba_pkg::rsp_t predict_response(bba_pkg::req_t r);
            bba_pkg::rsp_t rsp;
            int   lvl;
            int   first;
            int   idx;
            int   p;
            int   sh;
            int   addr;
            int   k;
            bit   fits;
            rsp = '{bba_pkg::ST_NO_SPACE, 5'd0, 3'd0};
            if (r.req_type == bba_pkg::REQ_ALLOC)
            begin
                alloc_reqs++;
                lvl = r.want_level;
                if (lvl > LEVELS)
                    rsp.status = bba_pkg::ST_BAD_LEVEL;
                else
                begin
                    first = 1 << lvl;
                    for (idx = first; idx < (2 << lvl); idx++)
                    begin
                        // leftmost clean node whose ancestors are all unused
                        fits = node_free[idx] && !node_split[idx];
                        for (p = idx >> 1; p >= 1 && fits; p = p >> 1)
                            fits = node_free[p];
                        if (fits)
                        begin
                            node_free[idx] = 1'b0;
                            for (p = idx >> 1; p >= 1; p = p >> 1)
                                node_split[p] = 1'b1;
                            rsp.status          = bba_pkg::ST_OK;
                            rsp.granted_address = 5'((idx - first) << (LEVELS - lvl));
                            live_addr.push_back(rsp.granted_address);
                            break;
                        end
                    end
                end
            end
            else
            begin
                free_reqs++;
                addr       = r.block_address;
                rsp.status = bba_pkg::ST_NOT_ALLOC;
                if (addr < (1 << LEVELS))
                begin
                    // topmost used node starting at addr, then merge upward
                    for (lvl = 0; lvl <= LEVELS; lvl++)
                    begin
                        sh = LEVELS - lvl;
                        if ((addr & ((1 << sh) - 1)) != 0)
                            continue;
                        idx = (1 << lvl) + (addr >> sh);
                        if (!node_free[idx])
                        begin
                            node_free[idx]  = 1'b1;
                            node_split[idx] = 1'b0;
                            while (idx > 1 && node_free[idx ^ 1] && !node_split[idx ^ 1])
                            begin
                                idx             = idx >> 1;
                                node_free[idx]  = 1'b1;
                                node_split[idx] = 1'b0;
                            end
                            rsp.status      = bba_pkg::ST_OK;
                            rsp.freed_level = 3'(lvl);
                            for (k = 0; k < live_addr.size(); k++)
                            begin
                                if (live_addr[k] == addr)
                                begin
                                    live_addr.delete(k);
                                    break;
                                end
                            end
                            break;
                        end
                    end
                end
            end
            status_seen[rsp.status]++;
            return rsp;
        endfunction

        function void note_request(bba_pkg::req_t r);
            pending_rsp.push_back(predict_response(r));
        endfunction

        function void check_result(bba_pkg::rsp_t got);
            bba_pkg::rsp_t want;
            if (pending_rsp.size() == 0)
            begin
                $error("response beat with no request outstanding: %p", got);
                fails++;
                return;
            end
            want = pending_rsp.pop_front();
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                fails++;
            end
            if (got.granted_address !== want.granted_address)
            begin
                $error("granted_address: expected %0d, got %0d",
                       want.granted_address, got.granted_address);
                fails++;
            end
            if (got.freed_level !== want.freed_level)
            begin
                $error("freed_level: expected %0d, got %0d",
                       want.freed_level, got.freed_level);
                fails++;
            end
        endfunction
    endclass

    logic          clk;
    logic          rst_n;
    logic          in_valid;
    logic          in_ready;
    bba_pkg::req_t in_data;
    logic          out_valid;
    logic          out_ready;
    bba_pkg::rsp_t out_data;
    int            idle_cycles;

    buddy_tree_tracker tracker = new();

    buddy_block_allocator #(
        .TREE_LEVELS(LEVELS)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // End the run when no beat moves on either side for too long.
    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    function automatic bba_pkg::req_t mk_req(logic kind, int lvl, int addr);
        bba_pkg::req_t r;
        r.req_type      = kind;
        r.want_level    = 3'(lvl);
        r.block_address = 5'(addr);
        return r;
    endfunction

    task automatic send_request(input bba_pkg::req_t r, input int gap);
        repeat (gap)
        begin
            @(negedge clk);
            in_valid = 1'b0;
        end
        @(negedge clk);
        in_valid = 1'b1;
        in_data  = r;
        do
            @(posedge clk);
        while (!in_ready);
        tracker.note_request(r);
    endtask

    // Response side: random stalls, bursts with none, and one long hold-off.
    initial
    begin
        int stall;
        int beats;
        bit rx_burst;
        out_ready = 1'b0;
        beats     = 0;
        rx_burst  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (beats % 40 == 0)
                rx_burst = ($urandom_range(0, 3) == 0);
            if (beats == HOLD_AT)
                stall = LONG_HOLD;
            else
                stall = rx_burst ? 0 : $urandom_range(0, 14);
            repeat (stall)
            begin
                @(negedge clk);
                out_ready = 1'b0;
            end
            @(negedge clk);
            out_ready = 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            tracker.check_result(out_data);
            beats++;
        end
    end

    initial
    begin
        bba_pkg::req_t directed[$];
        bba_pkg::req_t r;
        int   alloc_pct;
        int   pick;
        bit   tx_burst;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        alloc_pct = 50;
        tx_burst  = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        directed.push_back(mk_req(bba_pkg::REQ_ALLOC, 0, 0));   // whole region
        directed.push_back(mk_req(bba_pkg::REQ_ALLOC, 0, 0));   // no space
        directed.push_back(mk_req(bba_pkg::REQ_ALLOC, 5, 0));   // no space below a used root
        directed.push_back(mk_req(bba_pkg::REQ_FREE, 0, 5));    // nothing starts there
        directed.push_back(mk_req(bba_pkg::REQ_FREE, 7, 0));    // level field ignored
        directed.push_back(mk_req(bba_pkg::REQ_ALLOC, 6, 0));   // too deep
        directed.push_back(mk_req(bba_pkg::REQ_ALLOC, 7, 31));  // too deep, address ignored
        directed.push_back(mk_req(bba_pkg::REQ_ALLOC, 5, 0));
        directed.push_back(mk_req(bba_pkg::REQ_ALLOC, 5, 0));
        directed.push_back(mk_req(bba_pkg::REQ_ALLOC, 1, 0));
        directed.push_back(mk_req(bba_pkg::REQ_ALLOC, 1, 0));
        directed.push_back(mk_req(bba_pkg::REQ_ALLOC, 0, 0));
        directed.push_back(mk_req(bba_pkg::REQ_ALLOC, 3, 0));
        directed.push_back(mk_req(bba_pkg::REQ_ALLOC, 2, 0));
        directed.push_back(mk_req(bba_pkg::REQ_FREE, 0, 1));    // buddy still used
        directed.push_back(mk_req(bba_pkg::REQ_FREE, 0, 0));    // merge two levels up
        directed.push_back(mk_req(bba_pkg::REQ_FREE, 0, 31));   // inside a used block
        directed.push_back(mk_req(bba_pkg::REQ_FREE, 0, 16));
        directed.push_back(mk_req(bba_pkg::REQ_FREE, 0, 4));
        directed.push_back(mk_req(bba_pkg::REQ_FREE, 0, 8));    // merge back to the root
        directed.push_back(mk_req(bba_pkg::REQ_FREE, 0, 8));    // double free
        directed.push_back(mk_req(bba_pkg::REQ_ALLOC, 0, 0));
        directed.push_back(mk_req(bba_pkg::REQ_FREE, 0, 0));
        foreach (directed[k])
            send_request(directed[k], $urandom_range(0, 14));

        for (int n = 0; n < RANDOM_REQS; n++)
        begin
            // swing between filling and draining phases
            if (n % 40 == 0)
            begin
                alloc_pct = $urandom_range(15, 85);
                tx_burst  = ($urandom_range(0, 3) == 0);
            end
            r.want_level    = 3'($urandom_range(0, 7));
            r.block_address = 5'($urandom_range(0, 31));
            if ($urandom_range(1, 100) <= alloc_pct)
            begin
                r.req_type = bba_pkg::REQ_ALLOC;
                pick       = $urandom_range(0, 19);
                if (pick < 17)
                    r.want_level = 3'($urandom_range(2, 5));
                else if (pick < 19)
                    r.want_level = 3'($urandom_range(0, 1));
                else
                    r.want_level = 3'($urandom_range(6, 7));
            end
            else
            begin
                r.req_type = bba_pkg::REQ_FREE;
                if (tracker.live_addr.size() != 0 && $urandom_range(0, 9) != 0)
                    r.block_address =
                        tracker.live_addr[$urandom_range(0, tracker.live_addr.size() - 1)];
            end
            send_request(r, tx_burst ? 0 : $urandom_range(0, 14));
        end
        @(negedge clk);
        in_valid = 1'b0;

        while (tracker.pending_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (tracker.pending_rsp.size() != 0)
        begin
            $error("%0d responses never arrived", tracker.pending_rsp.size());
            tracker.fails++;
        end

        $display("covered %0d allocate and %0d free requests, random fill and drain",
                 tracker.alloc_reqs, tracker.free_reqs);
        $display("outcomes: %0d ok, %0d no space, %0d level too deep, %0d not allocated",
                 tracker.status_seen[bba_pkg::ST_OK],
                 tracker.status_seen[bba_pkg::ST_NO_SPACE],
                 tracker.status_seen[bba_pkg::ST_BAD_LEVEL],
                 tracker.status_seen[bba_pkg::ST_NOT_ALLOC]);
        if (tracker.fails == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

### buddy_block_allocator.f
hdl/bba_pkg.sv
hdl/bba_dp.sv
hdl/bba_ctrl.sv
hdl/buddy_block_allocator.sv
test/buddy_block_allocator_tb.sv
